>>> hdl/sctc_pkg.sv
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared widths, constants, types and the month-start table for the
// seconds-of-year to calendar time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sctc_pkg;

   localparam int SECONDS_W = 25;
   localparam int MONTH_W   = 4;
   localparam int MDAY_W    = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;
   localparam int YDAY_W    = 9;
   localparam int DAYREM_W  = 17;
   localparam int HOURREM_W = 12;

   localparam int NUM_STAGES = 6;

   localparam int MONTHS        = 12;
   localparam int DAYS_PER_YEAR = 365;

   // Day count = ((seconds >> 7) * DAY_RECIP) >> DAY_SHIFT, exact since
   // 86400 = 128 * 675 and the reciprocal error stays below 1/675.
   localparam int        DAY_PRESHIFT = 7;
   localparam int        DAY_SHIFT    = 28;
   localparam logic [18:0] DAY_RECIP  = 19'd397683;
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;

   // Hour = (rem * HOUR_RECIP) >> HOUR_SHIFT is exact for rem below one day.
   localparam int          HOUR_SHIFT    = 28;
   localparam logic [16:0] HOUR_RECIP    = 17'd74566;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

   // Minute = (rem * MIN_RECIP) >> MIN_SHIFT is exact for rem below one hour.
   localparam int          MIN_SHIFT    = 17;
   localparam logic [11:0] MIN_RECIP    = 12'd2185;
   localparam logic [5:0]  SECS_PER_MIN = 6'd60;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } sctc_ctl_type;

   typedef struct packed {
      logic [MONTH_W-1:0]  month_number;
      logic [MDAY_W-1:0]   day_of_month;
      logic [HOUR_W-1:0]   hour_of_day;
      logic [MINUTE_W-1:0] minute_of_hour;
      logic [SECOND_W-1:0] second_of_minute;
      logic                in_range;
   } sctc_result_type;

   // First day of year of month index 0 (January) .. 11, and 365 past the end.
   function automatic logic [YDAY_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
      logic [YDAY_W-1:0] start;
      case (idx)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd59;
         4'd3:    start = 9'd90;
         4'd4:    start = 9'd120;
         4'd5:    start = 9'd151;
         4'd6:    start = 9'd181;
         4'd7:    start = 9'd212;
         4'd8:    start = 9'd243;
         4'd9:    start = 9'd273;
         4'd10:   start = 9'd304;
         4'd11:   start = 9'd334;
         default: start = 9'd365;
      endcase
      return start;
   endfunction

   // Month 1..12 for a day of year below 365, from parallel compares.
   function automatic logic [MONTH_W-1:0] month_of_day(input logic [YDAY_W-1:0] yday);
      logic [MONTH_W-1:0] month;
      month = 4'd1;
      for (int i = 1; i < MONTHS; i++) begin
         if (yday >= month_start(MONTH_W'(i))) begin
            month = month + 4'd1;
         end
      end
      return month;
   endfunction

endpackage

`default_nettype wire

>>> hdl/sctc_if.sv
// ----------------------------------------------------------------------------
// sctc_req_if / sctc_rsp_if
// Valid/ready channels carrying a seconds count in and a calendar time out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sctc_req_if;
   import sctc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SECONDS_W-1:0] seconds_of_year;

   modport source (output valid, output seconds_of_year, input ready);
   modport sink   (input valid, input seconds_of_year, output ready);
endinterface

interface sctc_rsp_if;
   import sctc_pkg::*;
   logic                valid;
   logic                ready;
   logic [MONTH_W-1:0]  month_number;
   logic [MDAY_W-1:0]   day_of_month;
   logic [HOUR_W-1:0]   hour_of_day;
   logic [MINUTE_W-1:0] minute_of_hour;
   logic [SECOND_W-1:0] second_of_minute;
   logic                in_range;

   modport source (output valid, output month_number, output day_of_month,
                   output hour_of_day, output minute_of_hour,
                   output second_of_minute, output in_range, input ready);
   modport sink   (input valid, input month_number, input day_of_month,
                   input hour_of_day, input minute_of_hour,
                   input second_of_minute, input in_range, output ready);
endinterface

`default_nettype wire

>>> hdl/sctc_datapath.sv
// ----------------------------------------------------------------------------
// sctc_datapath
// Six-stage conversion datapath: day split, hour, month, minute, second.
// ----------------------------------------------------------------------------
`default_nettype none

module sctc_datapath
   import sctc_pkg::*;
(
   input  wire logic                 clock,
   input  wire sctc_ctl_type         ctl,
   input  wire logic [SECONDS_W-1:0] seconds_of_year,
   output sctc_result_type           result
);

   // Stage 1: day of year by reciprocal multiply.
   logic [SECONDS_W-1:0] s1_total_ff;
   logic [YDAY_W-1:0]    s1_yday_ff, s1_yday_in;
   logic [36:0]          s1_prod;

   assign s1_prod    = seconds_of_year[SECONDS_W-1:DAY_PRESHIFT] * DAY_RECIP;
   assign s1_yday_in = s1_prod[DAY_SHIFT +: YDAY_W];

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s1_total_ff <= seconds_of_year;
         s1_yday_ff  <= s1_yday_in;
      end
   end

   // Stage 2: seconds left within the day.
   logic [DAYREM_W-1:0] s2_rem_ff, s2_rem_in;
   logic [YDAY_W-1:0]   s2_yday_ff;
   logic [SECONDS_W-1:0] s2_day_secs;

   assign s2_day_secs = SECONDS_W'(s1_yday_ff) * SECONDS_W'(SECS_PER_DAY);
   assign s2_rem_in   = DAYREM_W'(s1_total_ff - s2_day_secs);

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s2_rem_ff  <= s2_rem_in;
         s2_yday_ff <= s1_yday_ff;
      end
   end

   // Stage 3: hour by reciprocal multiply, month by table compares.
   logic [HOUR_W-1:0]   s3_hour_ff, s3_hour_in;
   logic [DAYREM_W-1:0] s3_rem_ff;
   logic [YDAY_W-1:0]   s3_yday_ff;
   logic [MONTH_W-1:0]  s3_month_ff;
   logic                s3_ok_ff;
   logic [33:0]         s3_prod;

   assign s3_prod    = s2_rem_ff * HOUR_RECIP;
   assign s3_hour_in = s3_prod[HOUR_SHIFT +: HOUR_W];

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s3_hour_ff  <= s3_hour_in;
         s3_rem_ff   <= s2_rem_ff;
         s3_yday_ff  <= s2_yday_ff;
         s3_month_ff <= month_of_day(s2_yday_ff);
         s3_ok_ff    <= (s2_yday_ff < YDAY_W'(DAYS_PER_YEAR));
      end
   end

   // Stage 4: seconds within the hour and day of month.
   logic [HOURREM_W-1:0] s4_rem_ff, s4_rem_in;
   logic [HOUR_W-1:0]    s4_hour_ff;
   logic [MONTH_W-1:0]   s4_month_ff, s4_month_in;
   logic [MDAY_W-1:0]    s4_mday_ff, s4_mday_in;
   logic                 s4_ok_ff;
   logic [DAYREM_W-1:0]  s4_hour_secs;
   logic [YDAY_W-1:0]    s4_mday_wide;

   assign s4_hour_secs = DAYREM_W'(s3_hour_ff) * DAYREM_W'(SECS_PER_HOUR);
   assign s4_rem_in    = HOURREM_W'(s3_rem_ff - s4_hour_secs);
   assign s4_mday_wide = s3_yday_ff - month_start(s3_month_ff - 4'd1) + 9'd1;
   assign s4_mday_in   = s3_ok_ff ? s4_mday_wide[MDAY_W-1:0] : '0;
   assign s4_month_in  = s3_ok_ff ? s3_month_ff : '0;

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s4_rem_ff   <= s4_rem_in;
         s4_hour_ff  <= s3_hour_ff;
         s4_month_ff <= s4_month_in;
         s4_mday_ff  <= s4_mday_in;
         s4_ok_ff    <= s3_ok_ff;
      end
   end

   // Stage 5: minute by reciprocal multiply.
   logic [MINUTE_W-1:0]  s5_minute_ff, s5_minute_in;
   logic [HOURREM_W-1:0] s5_rem_ff;
   logic [HOUR_W-1:0]    s5_hour_ff;
   logic [MONTH_W-1:0]   s5_month_ff;
   logic [MDAY_W-1:0]    s5_mday_ff;
   logic                 s5_ok_ff;
   logic [23:0]          s5_prod;

   assign s5_prod      = s4_rem_ff * MIN_RECIP;
   assign s5_minute_in = s5_prod[MIN_SHIFT +: MINUTE_W];

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s5_minute_ff <= s5_minute_in;
         s5_rem_ff    <= s4_rem_ff;
         s5_hour_ff   <= s4_hour_ff;
         s5_month_ff  <= s4_month_ff;
         s5_mday_ff   <= s4_mday_ff;
         s5_ok_ff     <= s4_ok_ff;
      end
   end

   // Stage 6: second within the minute.
   sctc_result_type      s6_result_ff, s6_result_in;
   logic [HOURREM_W-1:0] s6_min_secs;

   assign s6_min_secs = HOURREM_W'(s5_minute_ff) * HOURREM_W'(SECS_PER_MIN);

   always_comb begin
      s6_result_in.month_number     = s5_month_ff;
      s6_result_in.day_of_month     = s5_mday_ff;
      s6_result_in.hour_of_day      = s5_hour_ff;
      s6_result_in.minute_of_hour   = s5_minute_ff;
      s6_result_in.second_of_minute = SECOND_W'(s5_rem_ff - s6_min_secs);
      s6_result_in.in_range         = s5_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         s6_result_ff <= s6_result_in;
      end
   end

   assign result = s6_result_ff;

endmodule

`default_nettype wire

>>> hdl/seconds_to_calendar_time_top.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_time_top
// Converts seconds since January 1 of a non-leap year into month, day,
// hour, minute and second, with an in-range flag for counts below 365 days.
// ----------------------------------------------------------------------------
// An accepted request passes through each register stage of the conversion
// datapath in turn before its result is valid.
// Throughput is one request per cycle while rsp is ready; each stage holds its item only while
// the stage after it is full and stalled, so bubbles close up.
// Synchronous active-high reset empties the pipeline; the datapath registers are not reset.
`default_nettype none

module seconds_to_calendar_time_top
   import sctc_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   sctc_req_if.sink   req,
   sctc_rsp_if.source rsp
);

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   sctc_ctl_type          ctl;
   sctc_result_type       result;

   // A stage loads when it is empty or its contents move on this cycle.
   always_comb begin
      ctl.load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ctl.load[i] = !valid_ff[i] || ctl.load[i+1];
      end
   end

   always_comb begin
      valid_in[0] = req.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (ctl.load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   sctc_datapath u_datapath (
      .clock           (clock),
      .ctl             (ctl),
      .seconds_of_year (req.seconds_of_year),
      .result          (result)
   );

   assign req.ready            = ctl.load[0] && !reset;
   assign rsp.valid            = valid_ff[NUM_STAGES-1];
   assign rsp.month_number     = result.month_number;
   assign rsp.day_of_month     = result.day_of_month;
   assign rsp.hour_of_day      = result.hour_of_day;
   assign rsp.minute_of_hour   = result.minute_of_hour;
   assign rsp.second_of_minute = result.second_of_minute;
   assign rsp.in_range         = result.in_range;

   // A result inside the year always carries a real month and day.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.in_range == (rsp.month_number != 4'd0)) &&
                    (rsp.in_range == (rsp.day_of_month != 5'd0)))
      else $error("in_range disagrees with month or day");

   // The time fields stay within one day.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.hour_of_day < 5'd24) && (rsp.minute_of_hour < 6'd60) &&
                    (rsp.second_of_minute < 6'd60))
      else $error("time field out of range");

   // An item accepted into an empty pipeline reaches the output while rsp.ready stays high.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && valid_ff == '0) ##1 (rsp.ready) ##1 (rsp.ready)
         ##1 (rsp.ready) ##1 (rsp.ready) ##1 (rsp.ready) |=> rsp.valid)
      else $error("request lost in the pipeline");

endmodule

`default_nettype wire
